// ----- design/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned DELAY_W       = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
    logic       scl_in;
  } i2cm_tick_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       start_failed;
  } i2cm_result_t;

endpackage

// ----- design/i2cm_if.sv -----
// Valid/ready channel interfaces for ticks, results and configuration.
interface i2cm_tick_if;
  logic                valid;
  logic                ready;
  i2cm_pkg::i2cm_tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_result_if;
  logic                  valid;
  logic                  ready;
  i2cm_pkg::i2cm_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [i2cm_pkg::DELAY_W-1:0]      data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/i2c_master_byte_engine.sv -----
// I2C master byte engine: one bus-sequencer step per accepted tick beat.
//
// The tick channel carries one beat per sequencer tick: an optional command
// (start, stop, write byte, read byte) and the sampled SDA and SCL levels.
// Every accepted tick beat produces exactly one result beat with the line
// drives, busy and done flags, the last received byte and the status flags.
// The cfg channel writes the delay length in ticks; it is always ready and
// is meant to be written while no command is running.
// A result beat is valid in the cycle after its tick beat is accepted, and a
// new tick beat can be accepted every cycle unless stalled. The whole step is
// computed in one pass from the sequencer registers into the result register.
// The result register holds a beat until it is taken; while it is full and
// not being taken, tick ready is low, so nothing is lost when the receiver
// stalls. Reset returns the sequencer to idle with both lines released,
// clears the flags and the received byte, and loads a delay of 100 ticks.
module i2c_master_byte_engine (
  input logic           clk,
  input logic           rst,
  i2cm_tick_if.sink     tick,
  i2cm_result_if.source result,
  i2cm_cfg_if.sink      cfg
);

  localparam logic [3:0] PH_IDLE          = 4'd0;
  localparam logic [3:0] PH_ST_CHECK      = 4'd1;
  localparam logic [3:0] PH_ST_SCL_LOW    = 4'd2;
  localparam logic [3:0] PH_ST_END        = 4'd3;
  localparam logic [3:0] PH_SP_RISE       = 4'd4;
  localparam logic [3:0] PH_SP_SDA        = 4'd5;
  localparam logic [3:0] PH_SP_END        = 4'd6;
  localparam logic [3:0] PH_WR_RISE       = 4'd7;
  localparam logic [3:0] PH_WR_FALL       = 4'd8;
  localparam logic [3:0] PH_WR_ACK_RISE   = 4'd9;
  localparam logic [3:0] PH_WR_ACK_SAMPLE = 4'd10;
  localparam logic [3:0] PH_WR_END        = 4'd11;
  localparam logic [3:0] PH_RD_RISE       = 4'd12;
  localparam logic [3:0] PH_RD_SAMPLE     = 4'd13;
  localparam logic [3:0] PH_RD_ACK_RISE   = 4'd14;
  localparam logic [3:0] PH_RD_END        = 4'd15;

  localparam logic [3:0] BYTE_BITS = 4'(i2cm_pkg::BITS_PER_BYTE);

  logic [i2cm_pkg::DELAY_W-1:0] delay_ticks;
  logic [3:0]                   phase, phase_next;
  logic [3:0]                   bit_index, bit_index_next;
  logic [7:0]                   shift_reg, shift_reg_next;
  logic [i2cm_pkg::DELAY_W-1:0] delay_count, delay_count_next;
  logic                         ack_choice, ack_choice_next;
  logic                         scl_pull, scl_pull_next;
  logic                         sda_pull, sda_pull_next;
  logic                         ack_flag, ack_flag_next;
  logic                         fail_flag, fail_flag_next;
  logic [7:0]                   rx_hold, rx_hold_next;
  logic                         done;
  logic [i2cm_pkg::DELAY_W-1:0] delay_load;
  logic [3:0]                   bit_inc;
  logic [7:0]                   shift_wr;
  logic                         out_valid;
  i2cm_pkg::i2cm_result_t       out_data;
  i2cm_pkg::i2cm_result_t       res_next;
  logic                         accept;
  i2cm_pkg::i2cm_tick_t         t;

  assign t          = tick.data;
  assign tick.ready = !out_valid || result.ready;
  assign accept     = tick.valid && tick.ready;
  assign cfg.ready  = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign delay_load = (delay_ticks == '0) ? {{(i2cm_pkg::DELAY_W-1){1'b0}}, 1'b1} : delay_ticks;
  assign bit_inc    = bit_index + 4'd1;
  assign shift_wr   = {shift_reg[6:0], 1'b0};

  always_comb begin
    phase_next       = phase;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    ack_choice_next  = ack_choice;
    scl_pull_next    = scl_pull;
    sda_pull_next    = sda_pull;
    ack_flag_next    = ack_flag;
    fail_flag_next   = fail_flag;
    rx_hold_next     = rx_hold;
    done             = 1'b0;

    if (phase == PH_IDLE) begin
      if (t.cmd_valid) begin
        ack_choice_next  = t.send_ack;
        bit_index_next   = '0;
        delay_count_next = delay_load;
        unique case (t.mode)
          i2cm_pkg::MODE_START: begin
            scl_pull_next = 1'b0;
            sda_pull_next = 1'b0;
            phase_next    = PH_ST_CHECK;
          end
          i2cm_pkg::MODE_STOP: begin
            scl_pull_next = 1'b1;
            sda_pull_next = 1'b1;
            phase_next    = PH_SP_RISE;
          end
          i2cm_pkg::MODE_WRITE: begin
            shift_reg_next = t.tx_byte;
            sda_pull_next  = !t.tx_byte[7];
            phase_next     = PH_WR_RISE;
          end
          default: begin
            shift_reg_next = '0;
            sda_pull_next  = 1'b0;
            phase_next     = PH_RD_RISE;
          end
        endcase
      end
    end else if (delay_count > {{(i2cm_pkg::DELAY_W-1){1'b0}}, 1'b1}) begin
      delay_count_next = delay_count - 1'b1;
    end else begin
      delay_count_next = delay_load;
      unique case (phase)
        PH_ST_CHECK: begin
          if (!t.sda_in || !t.scl_in) begin
            fail_flag_next = 1'b1;
            done           = 1'b1;
          end else begin
            sda_pull_next = 1'b1;
            phase_next    = PH_ST_SCL_LOW;
          end
        end
        PH_ST_SCL_LOW: begin
          scl_pull_next = 1'b1;
          phase_next    = PH_ST_END;
        end
        PH_ST_END: begin
          fail_flag_next = 1'b0;
          done           = 1'b1;
        end
        PH_SP_RISE: begin
          scl_pull_next = 1'b0;
          phase_next    = PH_SP_SDA;
        end
        PH_SP_SDA: begin
          sda_pull_next = 1'b0;
          phase_next    = PH_SP_END;
        end
        PH_SP_END: done = 1'b1;
        PH_WR_RISE: begin
          scl_pull_next = 1'b0;
          phase_next    = PH_WR_FALL;
        end
        PH_WR_FALL: begin
          scl_pull_next  = 1'b1;
          shift_reg_next = shift_wr;
          bit_index_next = bit_inc;
          if (bit_inc < BYTE_BITS) begin
            sda_pull_next = !shift_wr[7];
            phase_next    = PH_WR_RISE;
          end else begin
            sda_pull_next = 1'b0;
            phase_next    = PH_WR_ACK_RISE;
          end
        end
        PH_WR_ACK_RISE: begin
          scl_pull_next = 1'b0;
          phase_next    = PH_WR_ACK_SAMPLE;
        end
        PH_WR_ACK_SAMPLE: begin
          ack_flag_next = !t.sda_in;
          scl_pull_next = 1'b1;
          phase_next    = PH_WR_END;
        end
        PH_WR_END: begin
          sda_pull_next = 1'b1;
          done          = 1'b1;
        end
        PH_RD_RISE: begin
          scl_pull_next = 1'b0;
          phase_next    = PH_RD_SAMPLE;
        end
        PH_RD_SAMPLE: begin
          shift_reg_next = {shift_reg[6:0], t.sda_in};
          scl_pull_next  = 1'b1;
          bit_index_next = bit_inc;
          if (bit_inc < BYTE_BITS) begin
            sda_pull_next = 1'b0;
            phase_next    = PH_RD_RISE;
          end else begin
            sda_pull_next = ack_choice;
            phase_next    = PH_RD_ACK_RISE;
          end
        end
        PH_RD_ACK_RISE: begin
          scl_pull_next = 1'b0;
          phase_next    = PH_RD_END;
        end
        PH_RD_END: begin
          scl_pull_next = 1'b1;
          rx_hold_next  = shift_reg;
          done          = 1'b1;
        end
        default: done = 1'b1;
      endcase
      if (done) begin
        phase_next       = PH_IDLE;
        delay_count_next = '0;
      end
    end

    res_next.scl_pull_low = scl_pull_next;
    res_next.sda_pull_low = sda_pull_next;
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.done_res     = done;
    res_next.rx_byte      = rx_hold_next;
    res_next.ack_seen     = ack_flag_next;
    res_next.start_failed = fail_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= i2cm_pkg::DELAY_RESET;
    end else if (cfg.valid) begin
      delay_ticks <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= '0;
      shift_reg   <= '0;
      delay_count <= '0;
      ack_choice  <= 1'b0;
      scl_pull    <= 1'b0;
      sda_pull    <= 1'b0;
      ack_flag    <= 1'b0;
      fail_flag   <= 1'b0;
      rx_hold     <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      ack_choice  <= ack_choice_next;
      scl_pull    <= scl_pull_next;
      sda_pull    <= sda_pull_next;
      ack_flag    <= ack_flag_next;
      fail_flag   <= fail_flag_next;
      rx_hold     <= rx_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

endmodule

// ----- design/i2cm_checker.sv -----
// Port-level checker for the I2C master byte engine and its bind statement.
module i2cm_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   tick_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input i2cm_pkg::i2cm_result_t result_data
);

  // A command never reports done while still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result_data.done_res && result_data.busy_res))
    else $error("done_res and busy_res both high");

  // A full result register that is not taken blocks new tick beats.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !tick_ready)
    else $error("tick accepted while result stalled");

  // The result register is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // A stalled result beat holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
    else $error("stalled result beat changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_ready   (tick.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);
